// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file mmx_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define MMX_ASSERT_ALW(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define MMX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MMX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/mmx_pkg.sv -----
// Types, widths and constants of the motor mixer.
// No dependencies; used by every mixer module.
package mmx_pkg;

    localparam int ONE_Q14   = 16384;
    localparam int Q_SHIFT   = 14;
    localparam int CMD_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int CNT_W     = 4;
    localparam int FIELD_W   = 6;
    localparam int LAYOUT_W  = 48;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_OUT_W = 3;
    localparam int OUT_W     = 15;
    localparam int TERM_W    = 20;   // floor(cmd * gain / 2^14), sign included
    localparam int MIX_W     = 21;   // throttle plus three terms
    localparam int ADJ_W     = 22;   // mix plus airmode offset
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_GAIN = 3'd0,
        REG_ROLL_GAIN  = 3'd1,
        REG_YAW_GAIN   = 3'd2,
        REG_MOTOR_CNT  = 3'd3,
        REG_LAYOUT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   pitch_gain;
        logic [GAIN_W-1:0]   roll_gain;
        logic [GAIN_W-1:0]   yaw_gain;
        logic [CNT_W-1:0]    motor_count;
        logic [LAYOUT_W-1:0] layout;
    } cfg_t;

    // one operand set for the shared multiplier
    typedef struct packed {
        logic                    zero;   // sign factor 0
        logic                    neg;    // sign factor -1
        logic signed [CMD_W-1:0] cmd;
        logic [GAIN_W-1:0]       gain;
    } mul_req_t;

    // layout sign code 01 = +1, 11 = -1, others 0; flip negates the factor
    function automatic logic [1:0] sign_decode(input logic [1:0] code, input logic flip);
        logic zero;
        logic neg;
        zero = !((code == 2'b01) || (code == 2'b11));
        neg  = code[1] ^ flip;
        return {zero, neg};
    endfunction

endpackage

// ----- hdl/mmx_cfg_regs.sv -----
// Configuration register file of the motor mixer.
// Depends on mmx_pkg.
module mmx_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mmx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mmx_pkg::LAYOUT_W-1:0]    cfg_wdata,
    output mmx_pkg::cfg_t                   cfg
);
    import mmx_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pitch_gain  <= GAIN_W'(ONE_Q14);
            cfg_reg.roll_gain   <= GAIN_W'(ONE_Q14);
            cfg_reg.yaw_gain    <= GAIN_W'(ONE_Q14);
            cfg_reg.motor_count <= CNT_W'(4);
            cfg_reg.layout      <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PITCH_GAIN: cfg_reg.pitch_gain  <= cfg_wdata[GAIN_W-1:0];
                REG_ROLL_GAIN:  cfg_reg.roll_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_YAW_GAIN:   cfg_reg.yaw_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_MOTOR_CNT:  cfg_reg.motor_count <= cfg_wdata[CNT_W-1:0];
                REG_LAYOUT:     cfg_reg.layout      <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/mmx_mul_unit.sv -----
// Shared signed multiplier: sign * cmd * gain, floor-shifted by 14, registered.
// Depends on mmx_pkg.
module mmx_mul_unit (
    input  logic                                 aclk,
    input  mmx_pkg::mul_req_t                    req,
    output logic signed [mmx_pkg::TERM_W-1:0]    term
);
    import mmx_pkg::*;

    localparam int PROD_W = CMD_W + GAIN_W + 2;

    logic signed [CMD_W:0]    opa;
    logic signed [GAIN_W:0]   opb;
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] term_reg;

    always_comb begin
        if (req.zero) begin
            opa = '0;
        end else if (req.neg) begin
            opa = -((CMD_W+1)'(req.cmd));
        end else begin
            opa = (CMD_W+1)'(req.cmd);
        end
        opb  = $signed({1'b0, req.gain});
        prod = PROD_W'(opa) * PROD_W'(opb);
    end

    // arithmetic shift right = floor division by 2^14
    always_ff @(posedge aclk) begin
        term_reg <= prod[Q_SHIFT +: TERM_W];
    end

    assign term = term_reg;

endmodule

// ----- hdl/multirotor_airmode_motor_mixer.sv -----
// Top level of the airmode motor mixer: sequencer, mix store, output register.
// Depends on mmx_pkg, mmx_cfg_regs, mmx_mul_unit.
//
//  channel  dir  handshake               payload
//  s_       in   s_tvalid / s_tready     s_tdata: throttle, pitch, roll, yaw
//  m_       out  m_tvalid / m_tready     m_tdata: motor_index, motor_output; m_tlast
//  cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// One item at a time. Each enabled motor passes its pitch, roll and yaw
// products in turn through the one shared multiplier, then finishes its
// sum and takes a min/max compare; a disabled motor is skipped. Every
// result is formed in a load state and held in a send state until taken.
// s_tready is high only while idle. Synchronous active-low reset;
// configuration writes are always taken and are expected only while idle.
module multirotor_airmode_motor_mixer #(
    parameter int MAX_MOTORS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] throttle, [31:16] pitch_command, [47:32] roll_command,
    // [63:48] yaw_command
    input  logic [mmx_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] motor_index, [17:3] motor_output, [23:18] zero
    output logic [mmx_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmx_pkg::LAYOUT_W-1:0]        cfg_wdata
);
    import mmx_pkg::*;

    localparam int MIDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] STEP_PITCH = 2'd0;
    localparam logic [STEP_W-1:0] STEP_ROLL  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_YAW   = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SUM   = 2'd3;
    localparam logic signed [CMD_W-1:0] ONE_CMD = CMD_W'(ONE_Q14);
    localparam logic signed [MIX_W-1:0] ONE_MIX = MIX_W'(ONE_Q14);
    localparam logic signed [ADJ_W-1:0] ONE_ADJ = ADJ_W'(ONE_Q14);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MIX   = 7'b0000010,   // three products per enabled motor
        ST_EXTR  = 7'b0000100,   // min/max update
        ST_BOUND = 7'b0001000,   // overshoot / undershoot
        ST_SHIFT = 7'b0010000,   // airmode offset
        ST_LOAD  = 7'b0100000,   // form one result
        ST_SEND  = 7'b1000000    // hold result until taken
    } state_t;

    cfg_t     cfg;
    mul_req_t mul_req;
    logic signed [TERM_W-1:0] term;

    state_t state_reg, state_next;
    logic [MIDX_W-1:0] idx_reg, idx_next;
    logic [MIDX_W-1:0] last_reg, last_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OUT_W-1:0]  thr_reg, thr_next;
    logic signed [CMD_W-1:0] pc_reg, pc_next;
    logic signed [CMD_W-1:0] rc_reg, rc_next;
    logic signed [CMD_W-1:0] yc_reg, yc_next;
    logic signed [MIX_W-1:0] acc_reg, acc_next;
    logic signed [MIX_W-1:0] mn_reg, mn_next;
    logic signed [MIX_W-1:0] mx_reg, mx_next;
    logic any_reg, any_next;
    logic signed [MIX_W-1:0] over_reg, over_next;
    logic signed [MIX_W-1:0] under_reg, under_next;
    logic signed [ADJ_W-1:0] shift_reg, shift_next;
    logic [MAX_MOTORS-1:0] en_reg, en_next;
    logic [OUT_W-1:0] out_val_reg, out_val_next;
    logic out_last_reg, out_last_next;
    logic signed [MIX_W-1:0] mix_mem [MAX_MOTORS];
    logic mix_we;

    logic [FIELD_W-1:0]      field;
    logic [1:0]              sgn;
    logic signed [CMD_W-1:0] thr_in;
    logic [CNT_W-1:0]        cnt;
    logic [CNT_W-1:0]        cnt_m1;
    logic signed [MIX_W-1:0] thr_ext;
    logic signed [MIX_W-1:0] term_ext;
    logic signed [ADJ_W-1:0] sum;

    mmx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mmx_mul_unit u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .term (term)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = {{(M_DATA_W - OUT_W - IDX_OUT_W){1'b0}}, out_val_reg,
                       IDX_OUT_W'(idx_reg)};
    assign m_tlast  = out_last_reg;

    // layout field of the current motor
    assign field    = cfg.layout[FIELD_W*idx_reg +: FIELD_W];
    assign thr_in   = s_tdata[CMD_W-1:0];
    assign cnt      = cfg.motor_count;
    assign cnt_m1   = cnt - CNT_W'(1);
    assign thr_ext  = MIX_W'({1'b0, thr_reg});
    assign term_ext = MIX_W'(term);
    assign sum      = ADJ_W'(mix_mem[idx_reg]) + shift_reg;

    // multiplier operands by step: pitch and roll enter negated, yaw by spin
    always_comb begin
        sgn = 2'b00;
        mul_req.cmd  = yc_reg;
        mul_req.gain = cfg.yaw_gain;
        case (step_reg)
            STEP_PITCH: begin
                sgn          = sign_decode(field[2:1], 1'b1);
                mul_req.cmd  = pc_reg;
                mul_req.gain = cfg.pitch_gain;
            end
            STEP_ROLL: begin
                sgn          = sign_decode(field[4:3], 1'b1);
                mul_req.cmd  = rc_reg;
                mul_req.gain = cfg.roll_gain;
            end
            default: begin
                sgn = {1'b0, field[5]};
            end
        endcase
        mul_req.zero = sgn[1];
        mul_req.neg  = sgn[0];
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        step_next     = step_reg;
        thr_next      = thr_reg;
        pc_next       = pc_reg;
        rc_next       = rc_reg;
        yc_next       = yc_reg;
        acc_next      = acc_reg;
        mn_next       = mn_reg;
        mx_next       = mx_reg;
        any_next      = any_reg;
        over_next     = over_reg;
        under_next    = under_reg;
        shift_next    = shift_reg;
        en_next       = en_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        mix_we        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // throttle limited to 0..1.0
                    if (thr_in < 0) begin
                        thr_next = '0;
                    end else if (thr_in > ONE_CMD) begin
                        thr_next = OUT_W'(ONE_Q14);
                    end else begin
                        thr_next = thr_in[OUT_W-1:0];
                    end
                    pc_next   = s_tdata[2*CMD_W-1:CMD_W];
                    rc_next   = s_tdata[3*CMD_W-1:2*CMD_W];
                    yc_next   = s_tdata[4*CMD_W-1:3*CMD_W];
                    idx_next  = '0;
                    step_next = STEP_PITCH;
                    any_next  = 1'b0;
                    // count above the motor limit saturates
                    if (cnt > CNT_W'(MAX_MOTORS)) begin
                        last_next = MIDX_W'(MAX_MOTORS - 1);
                    end else begin
                        last_next = MIDX_W'(cnt_m1);
                    end
                    // zero motors: nothing to emit
                    if (cnt != '0) begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                case (step_reg)
                    STEP_PITCH: begin
                        if (!field[0]) begin
                            // disabled motor: no mix, skip the extremes
                            en_next[idx_reg] = 1'b0;
                            if (idx_reg == last_reg) begin
                                state_next = ST_BOUND;
                            end else begin
                                idx_next = idx_reg + MIDX_W'(1);
                            end
                        end else begin
                            step_next = STEP_ROLL;
                        end
                    end
                    STEP_ROLL: begin
                        acc_next  = thr_ext + term_ext;
                        step_next = STEP_YAW;
                    end
                    STEP_YAW: begin
                        acc_next  = acc_reg + term_ext;
                        step_next = STEP_SUM;
                    end
                    STEP_SUM: begin
                        acc_next         = acc_reg + term_ext;
                        mix_we           = 1'b1;
                        en_next[idx_reg] = 1'b1;
                        step_next        = STEP_PITCH;
                        state_next       = ST_EXTR;
                    end
                    default: ;
                endcase
            end
            ST_EXTR: begin
                if (!any_reg || acc_reg < mn_reg) begin
                    mn_next = acc_reg;
                end
                if (!any_reg || acc_reg > mx_reg) begin
                    mx_next = acc_reg;
                end
                any_next = 1'b1;
                if (idx_reg == last_reg) begin
                    state_next = ST_BOUND;
                end else begin
                    idx_next   = idx_reg + MIDX_W'(1);
                    state_next = ST_MIX;
                end
            end
            ST_BOUND: begin
                over_next  = (any_reg && mx_reg > ONE_MIX) ? mx_reg - ONE_MIX : '0;
                under_next = (any_reg && mn_reg < 0) ? -mn_reg : '0;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                shift_next = ADJ_W'(under_reg) - ADJ_W'(over_reg);
                idx_next   = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!en_reg[idx_reg] || sum < 0) begin
                    out_val_next = '0;
                end else if (sum > ONE_ADJ) begin
                    out_val_next = OUT_W'(ONE_Q14);
                end else begin
                    out_val_next = sum[OUT_W-1:0];
                end
                out_last_next = (idx_reg == last_reg);
                state_next    = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + MIDX_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_PITCH;
            any_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        thr_reg      <= thr_next;
        pc_reg       <= pc_next;
        rc_reg       <= rc_next;
        yc_reg       <= yc_next;
        acc_reg      <= acc_next;
        mn_reg       <= mn_next;
        mx_reg       <= mx_next;
        over_reg     <= over_next;
        under_reg    <= under_next;
        shift_reg    <= shift_next;
        en_reg       <= en_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        if (mix_we) begin
            mix_mem[idx_reg] <= acc_next;
        end
    end

endmodule

// ----- hdl/mmx_checker.sv -----
// Port-level checks of the motor mixer, bound to the top level.
// Depends on assert_macros.svh and mmx_pkg.
`include "assert_macros.svh"

module mmx_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mmx_pkg::M_DATA_W-1:0]     m_tdata,
    input logic                             m_tlast
);
    import mmx_pkg::*;

    logic out_wait;
    logic last_taken;

    assign out_wait   = m_tvalid && !m_tready;
    assign last_taken = m_tvalid && m_tready && m_tlast;

    // drive level never above 1.0, pad bits zero
    `MMX_ASSERT_ALW(a_out_range, aclk, aresetn, !m_tvalid || m_tdata[23:3] <= 21'(ONE_Q14))

    // one item at a time: no new item while results go out
    `MMX_ASSERT_IMP(a_busy_while_out, aclk, aresetn, m_tvalid, !s_tready)

    // the last result of a run frees the input side at once
    `MMX_ASSERT_NXT(a_last_ends_run, aclk, aresetn, last_taken, !m_tvalid && s_tready)

    // a stalled result holds
    `MMX_ASSERT_NXT(a_out_hold, aclk, aresetn, out_wait, m_tvalid && $stable({m_tlast, m_tdata}))

endmodule

bind multirotor_airmode_motor_mixer mmx_checker u_mmx_checker (.*);
